@@ rtl/r2h_pkg.sv @@
// ---------------------------------------------------------------------------
// r2h_pkg: shared types and constants of the RGB to HSL converter
// Widths of the pixel fields, of the division chain and of the stream words.
// ---------------------------------------------------------------------------
`default_nettype none

package r2h_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int SAT_BITS     = 16;

    // One quotient bit per cell; both quotients share the chain
    localparam int CELL_COUNT = (ANGLE_BITS > SAT_BITS) ? ANGLE_BITS : SAT_BITS;

    // Hue divisor is 6 * chroma, which needs three more bits than a channel
    localparam int HDIV_BITS = CHANNEL_BITS + 3;
    localparam int SUM_BITS  = CHANNEL_BITS + 1;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    localparam int IN_FIELD_BITS  = 3 * CHANNEL_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ANGLE_BITS + SAT_BITS + SUM_BITS + CHANNEL_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Payload handed from cell to cell
    typedef struct packed {
        logic [HDIV_BITS-1:0]    hrem;
        logic [HDIV_BITS-1:0]    hdiv;
        logic [CELL_COUNT-1:0]   hq;
        logic [CHANNEL_BITS-1:0] srem;
        logic [CHANNEL_BITS-1:0] sdiv;
        logic [CELL_COUNT-1:0]   sq;
        logic                    grey;
        logic                    sat_zero;
        logic [SUM_BITS-1:0]     sum;
        logic [CHANNEL_BITS-1:0] chroma;
    } cell_t;

endpackage

`default_nettype wire

@@ rtl/r2h_front.sv @@
// ---------------------------------------------------------------------------
// r2h_front: pixel front stage
// Finds max and min, chroma, lightness sum, hue sector numerator and both
// divisors, and registers them as the first word of the division chain.
// ---------------------------------------------------------------------------
`default_nettype none

module r2h_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [r2h_pkg::CHANNEL_BITS-1:0]  red,
    input  wire logic [r2h_pkg::CHANNEL_BITS-1:0]  green,
    input  wire logic [r2h_pkg::CHANNEL_BITS-1:0]  blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output r2h_pkg::cell_t                         out_data
);

    logic                              valid_reg;
    logic                              valid_next;
    r2h_pkg::cell_t                    data_reg;
    r2h_pkg::cell_t                    data_next;

    logic [r2h_pkg::CHANNEL_BITS-1:0]  mx;
    logic [r2h_pkg::CHANNEL_BITS-1:0]  mn;
    logic [r2h_pkg::CHANNEL_BITS-1:0]  chroma;
    logic [r2h_pkg::SUM_BITS-1:0]      sum;
    logic [r2h_pkg::SUM_BITS-1:0]      mid_offset;
    logic [r2h_pkg::SUM_BITS-1:0]      ch_max_w;
    logic [r2h_pkg::HDIV_BITS-1:0]     c_w;
    logic [r2h_pkg::HDIV_BITS-1:0]     c6;
    logic [r2h_pkg::HDIV_BITS-1:0]     r_w;
    logic [r2h_pkg::HDIV_BITS-1:0]     g_w;
    logic [r2h_pkg::HDIV_BITS-1:0]     b_w;
    logic [r2h_pkg::HDIV_BITS-1:0]     num;
    logic [r2h_pkg::CHANNEL_BITS-1:0]  sdiv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        chroma = mx - mn;
        sum    = r2h_pkg::SUM_BITS'(mx) + r2h_pkg::SUM_BITS'(mn);

        c_w = r2h_pkg::HDIV_BITS'(chroma);
        c6  = (c_w << 2) + (c_w << 1);
        r_w = r2h_pkg::HDIV_BITS'(red);
        g_w = r2h_pkg::HDIV_BITS'(green);
        b_w = r2h_pkg::HDIV_BITS'(blue);

        // Sector by largest channel; ties go red, then green
        if (red >= green && red >= blue)
        begin
            if (green >= blue)
            begin
                num = g_w - b_w;
            end
            else
            begin
                // wrap a negative red-sector hue by one full turn
                num = c6 - (b_w - g_w);
            end
        end
        else if (green >= blue)
        begin
            num = (c_w << 1) + b_w - r_w;
        end
        else
        begin
            num = (c_w << 2) + r_w - g_w;
        end

        ch_max_w   = r2h_pkg::SUM_BITS'(r2h_pkg::CH_MAX);
        mid_offset = (sum >= ch_max_w) ? (sum - ch_max_w) : (ch_max_w - sum);
        sdiv       = r2h_pkg::CHANNEL_BITS'(ch_max_w - mid_offset);

        data_next.hrem     = num;
        data_next.hdiv     = c6;
        data_next.hq       = '0;
        data_next.srem     = chroma;
        data_next.sdiv     = sdiv;
        data_next.sq       = '0;
        data_next.grey     = (chroma == '0);
        data_next.sat_zero = (sdiv == '0);
        data_next.sum      = sum;
        data_next.chroma   = chroma;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/r2h_div_cell.sv @@
// ---------------------------------------------------------------------------
// r2h_div_cell: one restoring division step for hue and saturation
// Shifts both partial remainders, subtracts the divisor where it fits and
// appends one quotient bit to each quotient, then hands the word on.
// ---------------------------------------------------------------------------
`default_nettype none

module r2h_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire r2h_pkg::cell_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output r2h_pkg::cell_t       out_data
);

    logic                               valid_reg;
    logic                               valid_next;
    r2h_pkg::cell_t                     data_reg;
    r2h_pkg::cell_t                     data_next;

    logic [r2h_pkg::HDIV_BITS:0]        hsh;
    logic [r2h_pkg::CHANNEL_BITS:0]     ssh;
    logic                               hbit;
    logic                               sbit;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;

        hsh  = {in_data.hrem, 1'b0};
        hbit = (hsh >= {1'b0, in_data.hdiv});
        if (hbit)
        begin
            data_next.hrem = r2h_pkg::HDIV_BITS'(hsh - {1'b0, in_data.hdiv});
        end
        else
        begin
            data_next.hrem = r2h_pkg::HDIV_BITS'(hsh);
        end
        data_next.hq = {in_data.hq[r2h_pkg::CELL_COUNT-2:0], hbit};

        // chroma never exceeds its divisor, so the quotient is all ones only when the two are equal
        ssh  = {in_data.srem, 1'b0};
        sbit = (ssh >= {1'b0, in_data.sdiv});
        if (sbit)
        begin
            data_next.srem = r2h_pkg::CHANNEL_BITS'(ssh - {1'b0, in_data.sdiv});
        end
        else
        begin
            data_next.srem = r2h_pkg::CHANNEL_BITS'(ssh);
        end
        data_next.sq = {in_data.sq[r2h_pkg::CELL_COUNT-2:0], sbit};

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsl_converter.sv @@
// ---------------------------------------------------------------------------
// rgb_to_hsl_converter: RGB pixel to hue, saturation, lightness and chroma
// A front stage followed by a row of restoring division cells.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Signals          | Payload
//   --------+-----------+------------------+--------------------------------
//   s_axis  | in        | tvalid/tready    | red, green, blue
//   m_axis  | out       | tvalid/tready    | hue, saturation, lightness_sum,
//           |           |                  | chroma
//
// One pixel per clock while m_axis_tready stays high: one front stage, then one
// cell per quotient bit. Every stage holds a valid bit; a stage takes a new
// transaction when it is empty or its neighbor takes its content, so bubbles
// collapse under stalls.
// Reset clears the valid bits only; the block keeps no state between pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // red, green, blue
    input  wire logic [r2h_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // hue, saturation, lightness_sum, chroma, zero fill
    output logic [r2h_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata
);

    localparam int CB = r2h_pkg::CHANNEL_BITS;
    localparam int N  = r2h_pkg::CELL_COUNT;

    logic                  stage_valid [N+1];
    logic                  stage_ready [N+1];
    r2h_pkg::cell_t        stage_data  [N+1];

    r2h_pkg::cell_t        last;
    logic [r2h_pkg::ANGLE_BITS-1:0] hue;
    logic [r2h_pkg::SAT_BITS-1:0]   saturation;

    r2h_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[CB-1:0]),
        .green     (s_axis_tdata[2*CB-1:CB]),
        .blue      (s_axis_tdata[3*CB-1:2*CB]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        r2h_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign stage_ready[N] = m_axis_tready;
    assign m_axis_tvalid  = stage_valid[N];
    assign last           = stage_data[N];

    // Drop the extra low quotient bits; grey and black/white force zero
    assign hue = last.grey ? '0 : last.hq[N-1 -: r2h_pkg::ANGLE_BITS];
    assign saturation = last.sat_zero ? '0 : last.sq[N-1 -: r2h_pkg::SAT_BITS];

    assign m_axis_tdata = r2h_pkg::OUT_DATA_BITS'({last.chroma, last.sum, saturation, hue});

endmodule

`default_nettype wire

@@ test/tb_rgb_to_hsl_converter.sv @@
// ---------------------------------------------------------------------------
// tb_rgb_to_hsl_converter: self-checking bench for the RGB to HSL converter
// Drives pixels on the input stream and computes the expected hue, saturation,
// lightness sum and chroma of each one. Every output transaction is checked
// in order against those values; some tests add random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;

    localparam int CHANNEL_BITS   = r2h_pkg::CHANNEL_BITS;
    localparam int ANGLE_BITS     = r2h_pkg::ANGLE_BITS;
    localparam int SAT_BITS       = r2h_pkg::SAT_BITS;
    localparam int SUM_BITS       = r2h_pkg::SUM_BITS;
    localparam int IN_FIELD_BITS  = r2h_pkg::IN_FIELD_BITS;
    localparam int IN_DATA_BITS   = r2h_pkg::IN_DATA_BITS;
    localparam int OUT_FIELD_BITS = r2h_pkg::OUT_FIELD_BITS;
    localparam int OUT_DATA_BITS  = r2h_pkg::OUT_DATA_BITS;
    localparam logic [CHANNEL_BITS-1:0] CH_MAX = r2h_pkg::CH_MAX;

    localparam int LATENCY   = 1 + r2h_pkg::CELL_COUNT;
    localparam int HUE_LO    = 0;
    localparam int SAT_LO    = ANGLE_BITS;
    localparam int SUM_LO    = ANGLE_BITS + SAT_BITS;
    localparam int CHROMA_LO = ANGLE_BITS + SAT_BITS + SUM_BITS;
    localparam int IDLE_PCT  = 38;

    typedef struct {
        logic [ANGLE_BITS-1:0]   hue;
        logic [SAT_BITS-1:0]     saturation;
        logic [SUM_BITS-1:0]     lightness_sum;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [OUT_DATA_BITS-OUT_FIELD_BITS-1:0] fill;
    } hsl_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // red, green, blue
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // hue, saturation, lightness_sum, chroma, fill

    hsl_t expected_hsl[$];
    int   error_count;
    int   pixels_sent;
    int   results_checked;
    bit   source_idle_en;
    bit   sink_stall_en;

    rgb_to_hsl_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // Integer HSL of one pixel; every quotient is floored
    function automatic hsl_t convert_pixel(logic [CHANNEL_BITS-1:0] r,
                                           logic [CHANNEL_BITS-1:0] g,
                                           logic [CHANNEL_BITS-1:0] b);
        hsl_t        res;
        logic [31:0] rw;
        logic [31:0] gw;
        logic [31:0] bw;
        logic [31:0] mx;
        logic [31:0] mn;
        logic [31:0] c;
        logic [31:0] sum;
        logic [31:0] num;
        logic [31:0] mid_offset;
        logic [31:0] ch_max_w;
        logic [31:0] sdiv;
        logic [31:0] q;
        rw       = 32'(r);
        gw       = 32'(g);
        bw       = 32'(b);
        ch_max_w = 32'(CH_MAX);
        mx = rw;
        mn = rw;
        if (gw > mx) mx = gw;
        if (bw > mx) mx = bw;
        if (gw < mn) mn = gw;
        if (bw < mn) mn = bw;
        c   = mx - mn;
        sum = mx + mn;

        if (c == 0)
        begin
            res.hue = '0;
        end
        else
        begin
            if (rw >= gw && rw >= bw)
            begin
                // wrap the negative part of the red sector into the last sixth
                num = (gw >= bw) ? (gw - bw) : (6 * c - (bw - gw));
            end
            else if (gw >= bw)
            begin
                num = 2 * c + bw - rw;
            end
            else
            begin
                num = 4 * c + rw - gw;
            end
            q = (num << ANGLE_BITS) / (6 * c);
            res.hue = q[ANGLE_BITS-1:0];
        end

        mid_offset = (sum >= ch_max_w) ? (sum - ch_max_w) : (ch_max_w - sum);
        sdiv       = ch_max_w - mid_offset;
        if (sdiv == 0)
        begin
            res.saturation = '0;
        end
        else
        begin
            q = (c << SAT_BITS) / sdiv;
            if (q > 32'({SAT_BITS{1'b1}}))
                q = 32'({SAT_BITS{1'b1}});
            res.saturation = q[SAT_BITS-1:0];
        end

        res.lightness_sum = sum[SUM_BITS-1:0];
        res.chroma        = c[CHANNEL_BITS-1:0];
        res.fill          = '0;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    // Check outputs, log accepted pixels, and drive the sink ready
    always @(posedge clk)
    begin
        hsl_t got;
        hsl_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hue           = m_axis_tdata[HUE_LO +: ANGLE_BITS];
                got.saturation    = m_axis_tdata[SAT_LO +: SAT_BITS];
                got.lightness_sum = m_axis_tdata[SUM_LO +: SUM_BITS];
                got.chroma        = m_axis_tdata[CHROMA_LO +: CHANNEL_BITS];
                got.fill          = m_axis_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS];
                if (expected_hsl.size() == 0)
                begin
                    report_mismatch("unexpected transaction", 0, 1);
                end
                else
                begin
                    want = expected_hsl.pop_front();
                    results_checked++;
                    if (got.hue !== want.hue)
                        report_mismatch("hue", want.hue, got.hue);
                    if (got.saturation !== want.saturation)
                        report_mismatch("saturation", want.saturation, got.saturation);
                    if (got.lightness_sum !== want.lightness_sum)
                        report_mismatch("lightness_sum", want.lightness_sum,
                                        got.lightness_sum);
                    if (got.chroma !== want.chroma)
                        report_mismatch("chroma", want.chroma, got.chroma);
                    if (got.fill !== want.fill)
                        report_mismatch("zero fill", want.fill, got.fill);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_hsl.push_back(convert_pixel(
                    s_axis_tdata[0 +: CHANNEL_BITS],
                    s_axis_tdata[CHANNEL_BITS +: CHANNEL_BITS],
                    s_axis_tdata[2*CHANNEL_BITS +: CHANNEL_BITS]));
                pixels_sent++;
            end
        end
        m_axis_tready <= sink_stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(logic [CHANNEL_BITS-1:0] r,
                              logic [CHANNEL_BITS-1:0] g,
                              logic [CHANNEL_BITS-1:0] b);
        while (source_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_BITS'({b, g, r});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_pixel();
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] v;
        r = CHANNEL_BITS'($urandom_range(0, CH_MAX));
        g = CHANNEL_BITS'($urandom_range(0, CH_MAX));
        b = CHANNEL_BITS'($urandom_range(0, CH_MAX));
        v = CHANNEL_BITS'($urandom_range(0, CH_MAX));
        case ($urandom_range(0, 9))
            0: send_pixel(v, v, v);                    // grey
            1: send_pixel(v, v, b);                    // red/green tie
            2: send_pixel(r, v, v);                    // green/blue tie
            3: send_pixel(v, g, v);                    // red/blue tie
            4: send_pixel(r & 8'h07, g & 8'h07, b & 8'h07);   // near black
            5: send_pixel(r | 8'hF8, g | 8'hF8, b | 8'hF8);   // near white
            6: send_pixel(CH_MAX, g, b);                // red dominant
            default: send_pixel(r, g, b);
        endcase
    endtask

    task automatic wait_drained();
        while (expected_hsl.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corner_pixels();
        logic [IN_FIELD_BITS-1:0] corners[] = '{
            24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
            24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h808080, 24'h010101,
            24'hFEFEFE, 24'h320AC8, 24'h0100FF, 24'h32C864, 24'hC86432,
            24'h00FEFF, 24'h000001, 24'hFEFFFF, 24'hFF8000, 24'h0055AA,
            24'hFFAA55, 24'h7F7F80
        };
        foreach (corners[i])
            send_pixel(corners[i][7:0], corners[i][15:8], corners[i][23:16]);
    endtask

    task automatic test_random_with_stalls(int count);
        source_idle_en = 1'b1;
        sink_stall_en  = 1'b1;
        repeat (count)
            send_random_pixel();
    endtask

    task automatic test_back_to_back(int count);
        source_idle_en = 1'b0;
        sink_stall_en  = 1'b0;
        repeat (count)
            send_random_pixel();
    endtask

    // Let the pipeline empty between bursts
    task automatic test_burst_then_drain(int bursts, int burst_len);
        source_idle_en = 1'b1;
        sink_stall_en  = 1'b1;
        repeat (bursts)
        begin
            repeat (burst_len)
                send_random_pixel();
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            wait_drained();
        end
    endtask

    initial
    begin
        int guard;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        error_count    = 0;
        pixels_sent    = 0;
        results_checked = 0;
        source_idle_en = 1'b0;
        sink_stall_en  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_random_with_stalls(380);
        test_back_to_back(160);
        test_burst_then_drain(4, 25);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (expected_hsl.size() != 0 && guard < 20 * LATENCY + 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge clk);
        if (expected_hsl.size() != 0)
            report_mismatch("results never delivered", 0, expected_hsl.size());

        $display("Converted %0d pixels, %0d results checked: corners, ties, greys,",
                 pixels_sent, results_checked);
        $display("random pixels with stalls, a full-rate stretch and drained bursts.");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not finish");
        $display("TB_ERROR");
        $finish;
    end

endmodule
